/* design/int8_mlp_two_two_one_lut_defines.svh */
// Assertion macros used by the int8 MLP top level.
`ifndef INT8_MLP_TWO_TWO_ONE_LUT_DEFINES_SVH
`define INT8_MLP_TWO_TWO_ONE_LUT_DEFINES_SVH

`ifndef ASSERT_OFF
`define I8MLP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define I8MLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define I8MLP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define I8MLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* design/i8mlp_pkg.sv */
// Types, constants and activation tables for the int8 MLP.
package i8mlp_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ProdW     = 2 * ByteW;
  localparam int unsigned FracShift = 4;
  localparam int unsigned FloorW    = ProdW - FracShift;
  localparam int unsigned SumW      = FloorW + 1;
  localparam int unsigned PredW     = 5;
  localparam int unsigned NumHidden = 2;

  localparam logic signed [ByteW-1:0] SatHigh = 8'sd127;
  localparam logic signed [ByteW-1:0] SatLow  = -8'sd128;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HIDDEN_WEIGHTS = 3'd0,
    CFG_HIDDEN_BIAS_A  = 3'd1,
    CFG_HIDDEN_BIAS_B  = 3'd2,
    CFG_OUT_WEIGHT_A   = 3'd3,
    CFG_OUT_WEIGHT_B   = 3'd4,
    CFG_OUT_BIAS       = 3'd5
  } cfg_idx_e;

  localparam logic [CfgDataW-1:0]     RstHiddenWeights = 32'h2BD3CE31;
  localparam logic signed [ByteW-1:0] RstHiddenBiasA   = -8'sd14;
  localparam logic signed [ByteW-1:0] RstHiddenBiasB   = -8'sd11;
  localparam logic signed [ByteW-1:0] RstOutWeightA    = 8'sd54;
  localparam logic signed [ByteW-1:0] RstOutWeightB    = 8'sd58;
  localparam logic signed [ByteW-1:0] RstOutBias       = 8'sd6;

  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } stage_ctrl_t;

  // ELU for negative bytes (index 128..255); non-negative bytes pass through
  localparam logic signed [ByteW-1:0] EluNegRom [128] = '{
    -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16,
    -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16,
    -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16,
    -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16,
    -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16,
    -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16,
    -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16,
    -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16,
    -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16, -8'sd16,
    -8'sd16, -8'sd15, -8'sd15, -8'sd15, -8'sd15, -8'sd15, -8'sd15, -8'sd15,
    -8'sd15, -8'sd15, -8'sd15, -8'sd15, -8'sd15, -8'sd15, -8'sd15, -8'sd15,
    -8'sd15, -8'sd15, -8'sd15, -8'sd14, -8'sd14, -8'sd14, -8'sd14, -8'sd14,
    -8'sd14, -8'sd14, -8'sd14, -8'sd13, -8'sd13, -8'sd13, -8'sd13, -8'sd13,
    -8'sd12, -8'sd12, -8'sd12, -8'sd12, -8'sd11, -8'sd11, -8'sd11, -8'sd10,
    -8'sd10, -8'sd10, -8'sd9,  -8'sd9,  -8'sd8,  -8'sd8,  -8'sd7,  -8'sd7,
    -8'sd6,  -8'sd6,  -8'sd5,  -8'sd4,  -8'sd4,  -8'sd3,  -8'sd2,  -8'sd1
  };

  localparam logic [PredW-1:0] SigRom [256] = '{
    5'd8,  5'd8,  5'd8,  5'd9,  5'd9,  5'd9,  5'd9,  5'd10,
    5'd10, 5'd10, 5'd10, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11,
    5'd12, 5'd12, 5'd12, 5'd12, 5'd12, 5'd13, 5'd13, 5'd13,
    5'd13, 5'd13, 5'd13, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14,
    5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd15, 5'd15, 5'd15,
    5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15,
    5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd16,
    5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,
    5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,
    5'd1,  5'd1,  5'd1,  5'd1,  5'd2,  5'd2,  5'd2,  5'd2,
    5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd3,  5'd3,
    5'd3,  5'd3,  5'd3,  5'd3,  5'd4,  5'd4,  5'd4,  5'd4,
    5'd4,  5'd5,  5'd5,  5'd5,  5'd5,  5'd5,  5'd6,  5'd6,
    5'd6,  5'd6,  5'd7,  5'd7,  5'd7,  5'd7,  5'd8,  5'd8
  };

  function automatic logic signed [ByteW-1:0] elu_f(input logic [ByteW-1:0] idx);
    logic signed [ByteW-1:0] res;
    if (idx[ByteW-1]) begin
      res = EluNegRom[idx[ByteW-2:0]];
    end else begin
      res = $signed(idx);
    end
    return res;
  endfunction

  function automatic logic [PredW-1:0] sigmoid_f(input logic [ByteW-1:0] idx);
    return SigRom[idx];
  endfunction

endpackage

/* design/i8mlp_neuron.sv */
// Two-input neuron: registered products, then floor, bias add and saturation.
module i8mlp_neuron (
  input  logic                                 clk_i,
  input  i8mlp_pkg::stage_ctrl_t               ctrl_i,
  input  logic signed [i8mlp_pkg::ByteW-1:0]   x_a_i,
  input  logic signed [i8mlp_pkg::ByteW-1:0]   x_b_i,
  input  logic signed [i8mlp_pkg::ByteW-1:0]   w_a_i,
  input  logic signed [i8mlp_pkg::ByteW-1:0]   w_b_i,
  input  logic signed [i8mlp_pkg::ByteW-1:0]   bias_i,
  output logic        [i8mlp_pkg::ByteW-1:0]   sat_o
);

  logic signed [i8mlp_pkg::ProdW-1:0]  prod_a_d, prod_b_d;
  logic signed [i8mlp_pkg::ProdW-1:0]  prod_a_q, prod_b_q;
  logic signed [i8mlp_pkg::FloorW-1:0] floor_a, floor_b;
  logic signed [i8mlp_pkg::SumW-1:0]   sum;
  logic        [i8mlp_pkg::ByteW-1:0]  sat_d, sat_q;

  assign prod_a_d = x_a_i * w_a_i;
  assign prod_b_d = x_b_i * w_b_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_a_q <= prod_a_d;
      prod_b_q <= prod_b_d;
    end
  end

  // dropping the fraction bits floors toward minus infinity
  assign floor_a = prod_a_q[i8mlp_pkg::ProdW-1:i8mlp_pkg::FracShift];
  assign floor_b = prod_b_q[i8mlp_pkg::ProdW-1:i8mlp_pkg::FracShift];
  assign sum     = i8mlp_pkg::SumW'(floor_a) + i8mlp_pkg::SumW'(floor_b)
                 + i8mlp_pkg::SumW'(bias_i);

  always_comb begin
    if (sum > i8mlp_pkg::SumW'(i8mlp_pkg::SatHigh)) begin
      sat_d = i8mlp_pkg::SatHigh;
    end else if (sum < i8mlp_pkg::SumW'(i8mlp_pkg::SatLow)) begin
      sat_d = i8mlp_pkg::SatLow;
    end else begin
      sat_d = sum[i8mlp_pkg::ByteW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      sat_q <= sat_d;
    end
  end

  assign sat_o = sat_q;

endmodule

/* design/int8_mlp_two_two_one_lut.sv */
// Top level of the 2-2-1 int8 perceptron with table activations.
// Four-stage pipeline taking one request per cycle while not stalled: hidden
// products, hidden sums, output products, output sum, each held in its own
// registers. The two hidden neurons run as parallel lanes, the output neuron
// merges them. A stalled result holds in the last stage while earlier stages
// keep filling, so input stall only rises once every stage holds a request.
// Register writes are taken every cycle (cfg_ready_o stays high); indexes 6
// and 7 are ignored. Write registers only while no request is in flight.
`include "int8_mlp_two_two_one_lut_defines.svh"

module int8_mlp_two_two_one_lut (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [i8mlp_pkg::ByteW-1:0]    feature_a_i,
  input  logic signed [i8mlp_pkg::ByteW-1:0]    feature_b_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic        [i8mlp_pkg::PredW-1:0]    prediction_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic        [i8mlp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic        [i8mlp_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned NumStages = 4;

  logic [i8mlp_pkg::CfgDataW-1:0]     hidden_weights_q;
  logic signed [i8mlp_pkg::ByteW-1:0] hidden_bias_q [i8mlp_pkg::NumHidden];
  logic signed [i8mlp_pkg::ByteW-1:0] out_weight_a_q, out_weight_b_q, out_bias_q;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] ready;

  i8mlp_pkg::stage_ctrl_t hid_ctrl, out_ctrl;

  logic [i8mlp_pkg::ByteW-1:0]        hid_sat [i8mlp_pkg::NumHidden];
  logic signed [i8mlp_pkg::ByteW-1:0] hid_act [i8mlp_pkg::NumHidden];
  logic [i8mlp_pkg::ByteW-1:0]        out_sat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hidden_weights_q <= i8mlp_pkg::RstHiddenWeights;
      hidden_bias_q[0] <= i8mlp_pkg::RstHiddenBiasA;
      hidden_bias_q[1] <= i8mlp_pkg::RstHiddenBiasB;
      out_weight_a_q   <= i8mlp_pkg::RstOutWeightA;
      out_weight_b_q   <= i8mlp_pkg::RstOutWeightB;
      out_bias_q       <= i8mlp_pkg::RstOutBias;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (i8mlp_pkg::cfg_idx_e'(cfg_index_i))
        i8mlp_pkg::CFG_HIDDEN_WEIGHTS: hidden_weights_q <= cfg_data_i;
        i8mlp_pkg::CFG_HIDDEN_BIAS_A:  hidden_bias_q[0] <= cfg_data_i[i8mlp_pkg::ByteW-1:0];
        i8mlp_pkg::CFG_HIDDEN_BIAS_B:  hidden_bias_q[1] <= cfg_data_i[i8mlp_pkg::ByteW-1:0];
        i8mlp_pkg::CFG_OUT_WEIGHT_A:   out_weight_a_q   <= cfg_data_i[i8mlp_pkg::ByteW-1:0];
        i8mlp_pkg::CFG_OUT_WEIGHT_B:   out_weight_b_q   <= cfg_data_i[i8mlp_pkg::ByteW-1:0];
        i8mlp_pkg::CFG_OUT_BIAS:       out_bias_q       <= cfg_data_i[i8mlp_pkg::ByteW-1:0];
        default: ;
      endcase
    end
  end

  // a stage may load when it is empty or its contents move on
  always_comb begin
    ready[NumStages-1] = !v_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ready[k] = !v_q[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ready[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (ready[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_stall_o = !ready[0];

  assign hid_ctrl = '{mul_en: ready[0], sum_en: ready[1]};
  assign out_ctrl = '{mul_en: ready[2], sum_en: ready[3]};

  for (genvar n = 0; n < i8mlp_pkg::NumHidden; n++) begin : g_lane
    i8mlp_neuron u_hidden (
      .clk_i  (clk_i),
      .ctrl_i (hid_ctrl),
      .x_a_i  (feature_a_i),
      .x_b_i  (feature_b_i),
      .w_a_i  (hidden_weights_q[2*n*i8mlp_pkg::ByteW +: i8mlp_pkg::ByteW]),
      .w_b_i  (hidden_weights_q[(2*n+1)*i8mlp_pkg::ByteW +: i8mlp_pkg::ByteW]),
      .bias_i (hidden_bias_q[n]),
      .sat_o  (hid_sat[n])
    );
    assign hid_act[n] = i8mlp_pkg::elu_f(hid_sat[n]);
  end

  i8mlp_neuron u_output (
    .clk_i  (clk_i),
    .ctrl_i (out_ctrl),
    .x_a_i  (hid_act[0]),
    .x_b_i  (hid_act[1]),
    .w_a_i  (out_weight_a_q),
    .w_b_i  (out_weight_b_q),
    .bias_i (out_bias_q),
    .sat_o  (out_sat)
  );

  assign out_valid_o  = v_q[NumStages-1];
  assign prediction_o = i8mlp_pkg::sigmoid_f(out_sat);

  `I8MLP_ASSERT_IMPL(a_empty_tail_no_stall, clk_i, rst_ni, !v_q[NumStages-1], !in_stall_o, "input stalled with an empty output stage")
  `I8MLP_ASSERT_NEXT(a_request_enters, clk_i, rst_ni, in_valid_i && !in_stall_o, v_q[0], "accepted request missing from first stage")
  `I8MLP_ASSERT_NEXT(a_blocked_stage_holds, clk_i, rst_ni, v_q[2] && !ready[3], v_q[2] && $stable(out_weight_a_q), "blocked request dropped from output product stage")
  `I8MLP_ASSERT_IMPL(a_prediction_range, clk_i, rst_ni, out_valid_o, prediction_o <= 5'd16, "prediction above one")

endmodule

/* test/tb_int8_mlp_two_two_one_lut.sv */
// Self-checking testbench for the 2-2-1 int8 perceptron, predicted from a register mirror.
module tb_int8_mlp_two_two_one_lut;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [i8mlp_pkg::CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [i8mlp_pkg::CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum int {MIX_WIDE, MIX_NARROW, MIX_EDGE} value_mix_e;

  logic                                  clk_i       = 1'b0;
  logic                                  rst_ni      = 1'b0;
  logic                                  in_valid_i  = 1'b0;
  logic                                  in_stall_o;
  logic signed [i8mlp_pkg::ByteW-1:0]    feature_a_i = '0;
  logic signed [i8mlp_pkg::ByteW-1:0]    feature_b_i = '0;
  logic                                  out_valid_o;
  logic                                  out_stall_i = 1'b0;
  logic        [i8mlp_pkg::PredW-1:0]    prediction_o;
  logic                                  cfg_valid_i = 1'b0;
  logic                                  cfg_ready_o;
  logic        [i8mlp_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic        [i8mlp_pkg::CfgDataW-1:0] cfg_data_i  = '0;

  // register mirror, reset values as documented for the block
  logic        [31:0] mirror_hidden_w = 32'h2BD3CE31;
  logic signed [7:0]  mirror_bias_a   = -8'sd14;
  logic signed [7:0]  mirror_bias_b   = -8'sd11;
  logic signed [7:0]  mirror_out_w_a  = 8'sd54;
  logic signed [7:0]  mirror_out_w_b  = 8'sd58;
  logic signed [7:0]  mirror_out_bias = 8'sd6;

  logic [i8mlp_pkg::PredW-1:0] pending_predictions [$];
  int unsigned      error_count  = 0;
  int unsigned      requests_sent = 0;
  int unsigned      results_seen = 0;
  int unsigned      writes_done  = 0;
  int unsigned      sink_hold    = 0;
  bit               idle_enable  = 1'b1;

  int8_mlp_two_two_one_lut DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .feature_a_i (feature_a_i),
    .feature_b_i (feature_b_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .prediction_o(prediction_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int floor_q4(logic signed [7:0] w, logic signed [7:0] x);
    return (int'(w) * int'(x)) >>> 4;
  endfunction

  function automatic logic [7:0] clamp_byte(int s);
    if (s > 127) s = 127;
    if (s < -128) s = -128;
    return s[7:0];
  endfunction

  // ELU: non-negative bytes pass, negative ones climb from -16 in steps
  function automatic logic signed [7:0] elu_of(logic [7:0] idx);
    int j;
    int steps;
    j = int'(idx[6:0]);
    if (!idx[7]) return idx;
    steps = (j >= 73) + (j >= 91) + (j >= 99) + (j >= 104) + (j >= 108) + (j >= 111)
          + (j >= 114) + (j >= 116) + (j >= 118) + (j >= 120) + (j >= 122)
          + (j >= 123) + (j >= 125) + (j >= 126) + (j >= 127);
    return 8'(steps - 16);
  endfunction

  function automatic logic [i8mlp_pkg::PredW-1:0] infer_prediction(logic signed [7:0] fa,
                                                                   logic signed [7:0] fb);
    logic signed [7:0] h_a;
    logic signed [7:0] h_b;
    logic [7:0]        idx;
    int                code;
    int                steps;
    h_a = elu_of(clamp_byte(int'(mirror_bias_a) + floor_q4(mirror_hidden_w[7:0], fa)
                            + floor_q4(mirror_hidden_w[15:8], fb)));
    h_b = elu_of(clamp_byte(int'(mirror_bias_b) + floor_q4(mirror_hidden_w[23:16], fa)
                            + floor_q4(mirror_hidden_w[31:24], fb)));
    idx = clamp_byte(int'(mirror_out_bias) + floor_q4(mirror_out_w_a, h_a)
                     + floor_q4(mirror_out_w_b, h_b));
    code = int'(idx);
    if (!idx[7]) begin
      steps = 8 + (code >= 3) + (code >= 7) + (code >= 11) + (code >= 16) + (code >= 21)
            + (code >= 27) + (code >= 37) + (code >= 55);
    end else begin
      steps = (code >= 202) + (code >= 220) + (code >= 230) + (code >= 236)
            + (code >= 241) + (code >= 246) + (code >= 250) + (code >= 254);
    end
    return steps[i8mlp_pkg::PredW-1:0];
  endfunction

  // ---------------------------------------------------------------- checking
  always @(posedge clk_i) begin
    logic [i8mlp_pkg::PredW-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_predictions.size() == 0) begin
        error_count++;
        $display("%0t: prediction %0d with no request pending", $time, prediction_o);
      end else begin
        want = pending_predictions.pop_front();
        if (prediction_o !== want) begin
          error_count++;
          $display("%0t: prediction mismatch on result %0d: expected %0d, actual %0d",
                   $time, results_seen, want, prediction_o);
        end
      end
      results_seen++;
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk_i) begin
    if (sink_hold == 0 && idle_enable && $urandom_range(0, 9) == 0)
      sink_hold = $urandom_range(1, 17);
    out_stall_i <= (sink_hold != 0);
    if (sink_hold != 0) sink_hold = sink_hold - 1;
  end

  // ---------------------------------------------------------------- drivers
  function automatic logic [7:0] pick_byte(value_mix_e mix);
    case (mix)
      MIX_NARROW: return 8'($urandom_range(0, 64)) - 8'd32;
      MIX_EDGE: begin
        case ($urandom_range(0, 4))
          0:       return 8'h80;
          1:       return 8'h7F;
          2:       return 8'h00;
          3:       return 8'hFF;
          default: return 8'h01;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] pad_byte(logic [7:0] b);
    logic [31:0] r;
    r = $urandom();
    r[7:0] = b;
    return r;
  endfunction

  task automatic send_request(input logic signed [7:0] fa, input logic signed [7:0] fb);
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    feature_a_i <= fa;
    feature_b_i <= fb;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_predictions.push_back(infer_prediction(fa, fb));
    requests_sent++;
  endtask

  task automatic send_random_request();
    send_request(pick_byte($urandom_range(0, 7) == 0 ? MIX_EDGE : MIX_WIDE),
                 pick_byte($urandom_range(0, 7) == 0 ? MIX_EDGE : MIX_WIDE));
  endtask

  task automatic settle_pipeline();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_predictions.size() != 0);
  endtask

  // leaves cfg_valid_i high so back-to-back writes need no re-raise
  task automatic write_reg(input logic [i8mlp_pkg::CfgIdxW-1:0] idx,
                           input logic [i8mlp_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      i8mlp_pkg::CFG_HIDDEN_WEIGHTS: mirror_hidden_w = data;
      i8mlp_pkg::CFG_HIDDEN_BIAS_A:  mirror_bias_a   = data[7:0];
      i8mlp_pkg::CFG_HIDDEN_BIAS_B:  mirror_bias_b   = data[7:0];
      i8mlp_pkg::CFG_OUT_WEIGHT_A:   mirror_out_w_a  = data[7:0];
      i8mlp_pkg::CFG_OUT_WEIGHT_B:   mirror_out_w_b  = data[7:0];
      i8mlp_pkg::CFG_OUT_BIAS:       mirror_out_bias = data[7:0];
      default: ;
    endcase
    writes_done++;
  endtask

  task automatic load_settings(input logic [31:0] hw, input logic [7:0] ba,
                               input logic [7:0] bb, input logic [7:0] wa,
                               input logic [7:0] wb, input logic [7:0] ob);
    settle_pipeline();
    write_reg(i8mlp_pkg::CFG_HIDDEN_WEIGHTS, hw);
    write_reg(i8mlp_pkg::CFG_HIDDEN_BIAS_A, pad_byte(ba));
    write_reg(i8mlp_pkg::CFG_HIDDEN_BIAS_B, pad_byte(bb));
    write_reg(i8mlp_pkg::CFG_OUT_WEIGHT_A, pad_byte(wa));
    write_reg(i8mlp_pkg::CFG_OUT_WEIGHT_B, pad_byte(wb));
    write_reg(i8mlp_pkg::CFG_OUT_BIAS, pad_byte(ob));
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_reset_defaults();
    send_request(8'sd0, 8'sd0);
    send_request(8'sd127, 8'sd127);
    send_request(-8'sd128, -8'sd128);
    send_request(8'sd127, -8'sd128);
    send_request(-8'sd128, 8'sd127);
    settle_pipeline();
  endtask

  task automatic test_floor_and_saturation();
    // small negative products must floor to -1, not truncate to 0
    load_settings(32'h10FF_FF01, 8'h00, 8'h00, 8'h01, 8'h10, 8'h00);
    send_request(-8'sd1, 8'sd0);
    send_request(8'sd0, 8'sd1);
    send_request(-8'sd17, 8'sd15);
    send_request(8'sd1, -8'sd1);
    load_settings(32'h7F7F_7F7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F);
    send_request(8'sd127, 8'sd127);
    send_request(-8'sd128, -8'sd128);
    send_request(8'sd127, -8'sd128);
    load_settings(32'h8080_8080, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80);
    send_request(8'sd127, 8'sd127);
    send_request(-8'sd128, -8'sd128);
    send_request(8'sd0, 8'sd0);
    settle_pipeline();
  endtask

  task automatic test_spare_indexes();
    write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_HI, 32'h0000_0000);
    write_reg(CFG_SPARE_HI, 32'hFFFF_FFFF);
    cfg_valid_i <= 1'b0;
    send_request(8'sd16, -8'sd16);
    send_request(-8'sd100, 8'sd55);
    send_request(8'sd3, 8'sd90);
    settle_pipeline();
  endtask

  task automatic test_random_settings();
    value_mix_e mix;
    for (int phase = 0; phase < 6; phase++) begin
      idle_enable = (phase != 2);
      mix = value_mix_e'(phase % 3);
      load_settings({pick_byte(mix), pick_byte(mix), pick_byte(mix), pick_byte(mix)},
                    pick_byte(mix), pick_byte(mix), pick_byte(mix), pick_byte(mix),
                    pick_byte(mix));
      repeat (110) send_random_request();
    end
    settle_pipeline();
  endtask

  task automatic test_back_to_back();
    idle_enable = 1'b0;
    load_settings($urandom(), pick_byte(MIX_NARROW), pick_byte(MIX_NARROW),
                  pick_byte(MIX_WIDE), pick_byte(MIX_WIDE), pick_byte(MIX_NARROW));
    repeat (60) send_random_request();
    settle_pipeline();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_floor_and_saturation();
    test_spare_indexes();
    test_random_settings();
    test_back_to_back();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d requests, checked %0d predictions, %0d register writes.",
             requests_sent, results_seen, writes_done);
    $display("Covered reset weights, floor and saturation edges, spare indexes, stalls.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/i8mlp_pkg.sv
design/i8mlp_neuron.sv
design/int8_mlp_two_two_one_lut.sv
test/tb_int8_mlp_two_two_one_lut.sv
